/* sv/sadc_pkg.sv */
// Package for the serial ADC sampler with bar-graph output.
// Holds register indexes, reset values, command layout and parameter defaults.
// No dependencies.
package sadc_pkg;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_CHANNEL      = 3'd0,
        REG_SINGLE_ENDED = 3'd1,
        REG_HALF_PERIOD  = 3'd2,
        REG_LEVEL_ONE    = 3'd3,
        REG_LEVEL_TWO    = 3'd4,
        REG_LEVEL_THREE  = 3'd5
    } cfg_index_t;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 10;

    localparam int CHANNEL_W = 3;
    localparam int PERIOD_W  = 8;
    localparam int LEVEL_W   = 10;
    localparam int SAMPLE_W  = 10;  // published sample field width
    localparam int LEDS_W    = 4;
    localparam int INDEX_W   = 5;   // serial clock counter

    localparam logic [CHANNEL_W-1:0] CHANNEL_RST      = 3'd0;
    localparam logic                 SINGLE_ENDED_RST = 1'b1;
    localparam logic [PERIOD_W-1:0]  HALF_PERIOD_RST  = 8'd1;
    localparam logic [LEVEL_W-1:0]   LEVEL_ONE_RST    = 10'd256;
    localparam logic [LEVEL_W-1:0]   LEVEL_TWO_RST    = 10'd512;
    localparam logic [LEVEL_W-1:0]   LEVEL_THREE_RST  = 10'd768;

    // Command bit positions within the command clocks
    localparam logic [INDEX_W-1:0] CMD_START_POS  = 5'd0;
    localparam logic [INDEX_W-1:0] CMD_MODE_POS   = 5'd1;
    localparam logic [INDEX_W-1:0] CMD_CH_MSB_POS = 5'd2;
    localparam logic [INDEX_W-1:0] CMD_CH_MID_POS = 5'd3;
    localparam logic [INDEX_W-1:0] CMD_CH_LSB_POS = 5'd4;

    // Parameter defaults
    localparam int SAMPLE_BITS_DEF    = 10;
    localparam int COMMAND_CLOCKS_DEF = 6;

    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 24;

endpackage

/* sv/spi_adc_sampler_bar_graph.sv */
// Serial ADC sampler: one input item per tick drives the SPI pins and LED bar.
// The result item for an accepted input item is registered and is on m_axis in the next cycle.
// Throughput: one item per cycle; a new item is taken while the last result
// waits, as long as the output register is empty or being drained.
// Reset (aresetn low, synchronous): engine idle with chip select high, sample,
// LEDs and output valid cleared, configuration back to its default values.
module spi_adc_sampler_bar_graph #(
    parameter int SAMPLE_BITS    = sadc_pkg::SAMPLE_BITS_DEF,   // 8 to 16
    parameter int COMMAND_CLOCKS = sadc_pkg::COMMAND_CLOCKS_DEF // 5 to 8
) (
    input  logic                             aclk,
    input  logic                             aresetn,

    // configuration write port
    input  logic                             cfg_we,
    input  logic [sadc_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [sadc_pkg::CFG_DATA_W-1:0]  cfg_wdata,

    // input items: one per tick
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [sadc_pkg::S_TDATA_W-1:0]   s_axis_tdata,  // [0] miso, [1] run, [7:2] zero

    // result items
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [sadc_pkg::M_TDATA_W-1:0]   m_axis_tdata   // [0] cs_n, [1] mosi, [2] sclk,
                                                            // [6:3] leds, [16:7] sample,
                                                            // [17] sample_done,
                                                            // [18] sample_changed, [23:19] zero
);
    import sadc_pkg::*;

    localparam int EXT_W = SAMPLE_BITS + SAMPLE_W;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_COMMAND,
        PH_READ
    } phase_t;

    // configuration
    logic [CHANNEL_W-1:0] channel_reg;
    logic                 single_ended_reg;
    logic [PERIOD_W-1:0]  half_period_reg;
    logic [LEVEL_W-1:0]   level_one_reg, level_two_reg, level_three_reg;

    // engine state
    phase_t                 phase_reg, phase_next;
    logic [INDEX_W-1:0]     clock_index_reg, clock_index_next;
    logic [PERIOD_W-1:0]    tick_count_reg, tick_count_next;
    logic [SAMPLE_BITS-1:0] shift_reg, shift_next;
    logic [SAMPLE_BITS-1:0] last_sample_reg, last_sample_next;
    logic [LEDS_W-1:0]      leds_reg, leds_next;
    logic                   sclk_reg, sclk_next;
    logic                   cs_n_reg, cs_n_next;

    // result register
    logic                   m_valid_reg;
    logic [M_TDATA_W-1:0]   m_data_reg;

    logic                   in_accept;
    logic                   miso, run;
    logic [PERIOD_W-1:0]    hp;
    logic [PERIOD_W-1:0]    tick_inc;
    logic                   done, changed, mosi;
    logic [EXT_W-1:0]       shift_ext, last_ext, lvl1_ext, lvl2_ext, lvl3_ext;
    logic [SAMPLE_W-1:0]    sample_out;

    // Take a new item whenever the output slot is free or being drained.
    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    assign miso = s_axis_tdata[0];
    assign run  = s_axis_tdata[1];

    // A zero half period behaves as one tick.
    assign hp       = (half_period_reg == '0) ? PERIOD_W'(1) : half_period_reg;
    assign tick_inc = tick_count_reg + PERIOD_W'(1);

    // Zero-extended views so comparisons work for any sample width.
    assign shift_ext = {{SAMPLE_W{1'b0}}, shift_reg};
    assign lvl1_ext  = {{SAMPLE_BITS{1'b0}}, level_one_reg};
    assign lvl2_ext  = {{SAMPLE_BITS{1'b0}}, level_two_reg};
    assign lvl3_ext  = {{SAMPLE_BITS{1'b0}}, level_three_reg};

    always_comb begin
        phase_next       = phase_reg;
        clock_index_next = clock_index_reg;
        tick_count_next  = tick_count_reg;
        shift_next       = shift_reg;
        last_sample_next = last_sample_reg;
        leds_next        = leds_reg;
        sclk_next        = sclk_reg;
        cs_n_next        = cs_n_reg;
        done             = 1'b0;
        changed          = 1'b0;

        if (phase_reg == PH_IDLE) begin
            // Start a conversion: select the ADC with the clock low.
            if (run) begin
                phase_next       = PH_COMMAND;
                cs_n_next        = 1'b0;
                sclk_next        = 1'b0;
                clock_index_next = '0;
                tick_count_next  = '0;
                shift_next       = '0;
            end
        end else begin
            tick_count_next = tick_inc;
            if (tick_inc >= hp) begin
                tick_count_next = '0;
                if (!sclk_reg) begin
                    // Rising edge: read clocks after the null bit shift in miso.
                    sclk_next = 1'b1;
                    if (phase_reg == PH_READ && clock_index_reg != '0) begin
                        shift_next = {shift_reg[SAMPLE_BITS-2:0], miso};
                    end
                end else begin
                    // Falling edge: advance to the next serial clock.
                    sclk_next        = 1'b0;
                    clock_index_next = clock_index_reg + INDEX_W'(1);
                    if (phase_reg == PH_COMMAND) begin
                        if (clock_index_next >= INDEX_W'(COMMAND_CLOCKS)) begin
                            phase_next       = PH_READ;
                            clock_index_next = '0;
                        end
                    end else if (clock_index_next >= INDEX_W'(SAMPLE_BITS + 1)) begin
                        // Last read clock done: publish, update the bar, deselect.
                        done             = 1'b1;
                        changed          = (shift_reg != last_sample_reg);
                        last_sample_next = shift_reg;
                        leds_next        = {shift_ext > lvl3_ext, shift_ext > lvl2_ext,
                                            shift_ext > lvl1_ext, 1'b1};
                        phase_next       = PH_IDLE;
                        cs_n_next        = 1'b1;
                        clock_index_next = '0;
                    end
                end
            end
        end
    end

    // Command bit for the clock now under way; zero outside the command phase.
    always_comb begin
        mosi = 1'b0;
        if (phase_next == PH_COMMAND) begin
            case (clock_index_next)
                CMD_START_POS:  mosi = 1'b1;
                CMD_MODE_POS:   mosi = single_ended_reg;
                CMD_CH_MSB_POS: mosi = channel_reg[2];
                CMD_CH_MID_POS: mosi = channel_reg[1];
                CMD_CH_LSB_POS: mosi = channel_reg[0];
                default:        mosi = 1'b0;
            endcase
        end
    end

    // Low bits of the stored sample, zero-padded when the sample is narrow.
    assign last_ext   = {{SAMPLE_W{1'b0}}, last_sample_next};
    assign sample_out = last_ext[SAMPLE_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            channel_reg      <= CHANNEL_RST;
            single_ended_reg <= SINGLE_ENDED_RST;
            half_period_reg  <= HALF_PERIOD_RST;
            level_one_reg    <= LEVEL_ONE_RST;
            level_two_reg    <= LEVEL_TWO_RST;
            level_three_reg  <= LEVEL_THREE_RST;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_CHANNEL:      channel_reg      <= cfg_wdata[CHANNEL_W-1:0];
                REG_SINGLE_ENDED: single_ended_reg <= cfg_wdata[0];
                REG_HALF_PERIOD:  half_period_reg  <= cfg_wdata[PERIOD_W-1:0];
                REG_LEVEL_ONE:    level_one_reg    <= cfg_wdata[LEVEL_W-1:0];
                REG_LEVEL_TWO:    level_two_reg    <= cfg_wdata[LEVEL_W-1:0];
                REG_LEVEL_THREE:  level_three_reg  <= cfg_wdata[LEVEL_W-1:0];
                default:          ;  // unknown index: drop the write
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_IDLE;
            clock_index_reg <= '0;
            tick_count_reg  <= '0;
            shift_reg       <= '0;
            last_sample_reg <= '0;
            leds_reg        <= '0;
            sclk_reg        <= 1'b0;
            cs_n_reg        <= 1'b1;
            m_valid_reg     <= 1'b0;
        end else begin
            if (in_accept) begin
                phase_reg       <= phase_next;
                clock_index_reg <= clock_index_next;
                tick_count_reg  <= tick_count_next;
                shift_reg       <= shift_next;
                last_sample_reg <= last_sample_next;
                leds_reg        <= leds_next;
                sclk_reg        <= sclk_next;
                cs_n_reg        <= cs_n_next;
                m_valid_reg     <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload: load with each accepted item, hold otherwise.
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            m_data_reg <= {5'b0, changed, done, sample_out, leds_next,
                           sclk_next, mosi, cs_n_next};
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

/* dv/testbench.sv */
// Self-checking testbench for spi_adc_sampler_bar_graph: it drives tick items, keeps its own
// model of the serial ADC engine and the LED bar, and compares every result item field by field.
// Depends on sadc_pkg and the spi_adc_sampler_bar_graph RTL.
`timescale 1ns / 1ps

module testbench;
    import sadc_pkg::*;

    // Run limit, well above the slowest correct run (long clock phases, stalls, idling)
    localparam time LIMIT_NS = 4_000_000;
    // Cycles to keep watching the result channel after the last expected item
    localparam int  DRAIN_CYCLES = 8;
    // Ticks with the slowest serial clock: one full low phase and the rise after it
    localparam int  SLOW_TICKS = 300;

    // Register indexes that the block must ignore
    localparam logic [CFG_ADDR_W-1:0] REG_UNUSED_LO = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_UNUSED_HI = 3'd7;

    // Engine phases of the prediction
    typedef enum logic [1:0] {
        ENG_IDLE,
        ENG_COMMAND,
        ENG_READ
    } eng_phase_t;

    // One result item as it sits in m_axis_tdata, highest field first
    typedef struct packed {
        logic [M_TDATA_W-20:0] pad;
        logic                  changed;
        logic                  done;
        logic [SAMPLE_W-1:0]   sample;
        logic [LEDS_W-1:0]     leds;
        logic                  sclk;
        logic                  mosi;
        logic                  cs_n;
    } adc_pins_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_we;
    logic [CFG_ADDR_W-1:0]  cfg_addr;
    logic [CFG_DATA_W-1:0]  cfg_wdata;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [S_TDATA_W-1:0]   s_axis_tdata;   // [0] miso, [1] run, rest zero
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [M_TDATA_W-1:0]   m_axis_tdata;   // [0] cs_n, [1] mosi, [2] sclk, [6:3] leds,
                                            // [16:7] sample, [17] sample_done,
                                            // [18] sample_changed, rest zero

    // Shadow copy of the configuration registers
    logic [CHANNEL_W-1:0]   chan_q   = CHANNEL_RST;
    logic                   mode_q   = SINGLE_ENDED_RST;
    logic [PERIOD_W-1:0]    half_q   = HALF_PERIOD_RST;
    logic [LEVEL_W-1:0]     lvl1_q   = LEVEL_ONE_RST;
    logic [LEVEL_W-1:0]     lvl2_q   = LEVEL_TWO_RST;
    logic [LEVEL_W-1:0]     lvl3_q   = LEVEL_THREE_RST;

    // Predicted engine state
    eng_phase_t             eng_phase = ENG_IDLE;
    logic [INDEX_W-1:0]     clk_idx   = '0;
    logic [PERIOD_W-1:0]    tick_cnt  = '0;
    logic [SAMPLE_W-1:0]    shift_reg = '0;
    logic [SAMPLE_W-1:0]    last_smp  = '0;
    logic [LEDS_W-1:0]      led_reg   = '0;
    logic                   sclk_lvl  = 1'b0;
    logic                   cs_lvl    = 1'b1;
    bit                     sample_ready = 1'b0;   // last predicted tick finished a conversion

    adc_pins_t              pending_pins[$];       // predicted result items, oldest first
    int                     fail_count    = 0;
    int                     items_sent    = 0;
    int                     send_idle_pct = 0;
    int                     recv_idle_pct = 0;
    int                     hold_left     = 0;     // cycles the receiver still holds off

    spi_adc_sampler_bar_graph u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Advance the model by one tick and return the pin levels that follow it.
    function automatic adc_pins_t advance_adc(input logic miso, input logic run);
        adc_pins_t           pins;
        logic [PERIOD_W-1:0] hp;
        logic [SAMPLE_W-1:0] s;
        logic                done;
        logic                changed;
        hp      = (half_q == '0) ? PERIOD_W'(1) : half_q;  // zero half period behaves as one
        done    = 1'b0;
        changed = 1'b0;
        if (eng_phase == ENG_IDLE) begin
            if (run) begin
                // select the ADC and start the command clocks from a low clock
                eng_phase = ENG_COMMAND;
                cs_lvl    = 1'b0;
                sclk_lvl  = 1'b0;
                clk_idx   = '0;
                tick_cnt  = '0;
                shift_reg = '0;
            end
        end else begin
            tick_cnt = tick_cnt + 1'b1;
            if (tick_cnt >= hp) begin
                tick_cnt = '0;
                if (!sclk_lvl) begin
                    sclk_lvl = 1'b1;
                    // rising edge: shift in miso, except during the null bit clock
                    if (eng_phase == ENG_READ && clk_idx >= 1)
                        shift_reg = {shift_reg[SAMPLE_W-2:0], miso};
                end else begin
                    sclk_lvl = 1'b0;
                    clk_idx  = clk_idx + 1'b1;
                    if (eng_phase == ENG_COMMAND) begin
                        if (clk_idx >= COMMAND_CLOCKS_DEF) begin
                            eng_phase = ENG_READ;
                            clk_idx   = '0;
                        end
                    end else if (clk_idx >= SAMPLE_BITS_DEF + 1) begin
                        // falling edge of the last read clock: publish and deselect
                        s         = shift_reg;
                        done      = 1'b1;
                        changed   = (s != last_smp);
                        last_smp  = s;
                        led_reg   = {s > lvl3_q, s > lvl2_q, s > lvl1_q, 1'b1};
                        eng_phase = ENG_IDLE;
                        cs_lvl    = 1'b1;
                        clk_idx   = '0;
                    end
                end
            end
        end
        sample_ready = done;

        pins         = '0;
        pins.cs_n    = cs_lvl;
        pins.sclk    = sclk_lvl;
        pins.leds    = led_reg;
        pins.sample  = last_smp;
        pins.done    = done;
        pins.changed = changed;
        if (eng_phase == ENG_COMMAND) begin
            case (clk_idx) inside
                CMD_START_POS:  pins.mosi = 1'b1;
                CMD_MODE_POS:   pins.mosi = mode_q;
                CMD_CH_MSB_POS, CMD_CH_MID_POS, CMD_CH_LSB_POS:
                    pins.mosi = chan_q[2'(CMD_CH_LSB_POS - clk_idx)];
                default:        pins.mosi = 1'b0;   // trailing zero and any extra clocks
            endcase
        end
        return pins;
    endfunction

    function automatic int field_mismatch(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    // Check every accepted result item against the oldest prediction.
    always @(posedge aclk) begin
        adc_pins_t got;
        adc_pins_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (pending_pins.size() == 0) begin
                $display("%0t: result item with none expected: %h", $time, got);
                fail_count++;
            end else begin
                want = pending_pins.pop_front();
                fail_count += field_mismatch("cs_n", want.cs_n, got.cs_n)
                            + field_mismatch("mosi", want.mosi, got.mosi)
                            + field_mismatch("sclk", want.sclk, got.sclk)
                            + field_mismatch("leds", want.leds, got.leds)
                            + field_mismatch("sample", want.sample, got.sample)
                            + field_mismatch("sample_done", want.done, got.done)
                            + field_mismatch("sample_changed", want.changed, got.changed)
                            + field_mismatch("pad", want.pad, got.pad);
            end
        end
    end

    // Receiver: stall at random, or hold off entirely while hold_left runs down.
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Offer one tick item, wait for its handshake and record the predicted result.
    // Enter and leave at a falling edge.
    task automatic send_item(input logic miso, input logic run);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(S_TDATA_W-2){1'b0}}, run, miso};
        do @(posedge aclk); while (!s_axis_tready);
        pending_pins.push_back(advance_adc(miso, run));
        items_sent++;
        @(negedge aclk);
    endtask

    // Drive ticks with run high until one conversion completes. Unless noisy, place the
    // bits of target on miso at the read clocks so the ADC returns that value.
    task automatic convert(input logic [SAMPLE_W-1:0] target, input bit noisy);
        logic bit_in;
        do begin
            if (!noisy && eng_phase == ENG_READ && clk_idx >= 1 && clk_idx <= SAMPLE_W)
                bit_in = target[4'(SAMPLE_W - int'(clk_idx))];
            else
                bit_in = 1'($urandom_range(1));
            send_item(bit_in, 1'b1);
        end while (!sample_ready);
    endtask

    // Drop valid and wait until every predicted result has been received.
    task automatic settle;
        s_axis_tvalid <= 1'b0;
        while (pending_pins.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Write one register; cfg_we stays high for the caller to drop or reuse.
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            REG_CHANNEL:      chan_q = val[CHANNEL_W-1:0];
            REG_SINGLE_ENDED: mode_q = val[0];
            REG_HALF_PERIOD:  half_q = val[PERIOD_W-1:0];
            REG_LEVEL_ONE:    lvl1_q = val[LEVEL_W-1:0];
            REG_LEVEL_TWO:    lvl2_q = val[LEVEL_W-1:0];
            REG_LEVEL_THREE:  lvl3_q = val[LEVEL_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
    endtask

    // Settle the block, then write all six registers.
    task automatic program_regs(input logic [CFG_DATA_W-1:0] ch, input logic [CFG_DATA_W-1:0] se,
                                input logic [CFG_DATA_W-1:0] hp, input logic [CFG_DATA_W-1:0] l1,
                                input logic [CFG_DATA_W-1:0] l2, input logic [CFG_DATA_W-1:0] l3);
        settle();
        write_reg(REG_CHANNEL, ch);
        write_reg(REG_SINGLE_ENDED, se);
        write_reg(REG_HALF_PERIOD, hp);
        write_reg(REG_LEVEL_ONE, l1);
        write_reg(REG_LEVEL_TWO, l2);
        write_reg(REG_LEVEL_THREE, l3);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [LEVEL_W-1:0] pick_level();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return LEVEL_W'($urandom_range(1023));
        endcase
    endfunction

    // Idle ticks after reset: chip select high, LEDs dark, miso ignored.
    task automatic test_idle_outputs;
        send_item(1'b0, 1'b0);
        send_item(1'b1, 1'b0);
        send_item(1'b1, 1'b0);
        send_item(1'b0, 1'b0);
    endtask

    // Zero then full scale with the reset settings; repeat values to see changed stay low.
    task automatic test_full_scale;
        convert('0, 1'b0);      // equals the cleared sample: no change, only LED0 lit
        convert('1, 1'b0);      // above all three levels
        convert('1, 1'b0);
    endtask

    // Samples equal to a level do not light its LED; zero half period runs as one.
    task automatic test_level_edges;
        program_regs(10'd5, 10'd0, 10'd0, 10'd300, 10'd301, 10'd1023);
        convert(10'd300, 1'b0);
        convert(10'd301, 1'b0);
        convert(10'd1023, 1'b0);
        program_regs(10'h3FA, 10'h3FF, 10'd1, 10'd0, 10'd0, 10'd0);
        convert(10'd0, 1'b0);
        convert(10'd1, 1'b0);
    endtask

    // Drop run mid-conversion: the conversion completes and no new one starts.
    task automatic test_run_release;
        send_item(1'($urandom_range(1)), 1'b1);
        do send_item(1'($urandom_range(1)), 1'b0); while (!sample_ready);
        repeat (3) send_item(1'($urandom_range(1)), 1'b0);
    endtask

    // Writes to unused indexes leave the settings alone.
    task automatic test_unused_regs;
        settle();
        write_reg(REG_UNUSED_LO, CFG_DATA_W'($urandom_range(1023)));
        write_reg(REG_UNUSED_HI, CFG_DATA_W'($urandom_range(1023)));
        cfg_we <= 1'b0;
        convert(SAMPLE_W'($urandom_range(1023)), 1'b0);
    endtask

    // Random settings and ticks: mostly clean conversions, some noise and run drops.
    task automatic test_random(input int send_pct, input int recv_pct, input int n_items);
        int                  start;
        logic [SAMPLE_W-1:0] target;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (3) begin
            program_regs(CFG_DATA_W'($urandom_range(1023)), CFG_DATA_W'($urandom_range(1023)),
                         ($urandom_range(7) == 0) ? CFG_DATA_W'($urandom_range(4, 8))
                                                  : CFG_DATA_W'($urandom_range(3)),
                         pick_level(), pick_level(), pick_level());
            start = items_sent;
            while (items_sent - start < n_items / 3) begin
                case ($urandom_range(9))
                    0: repeat ($urandom_range(1, 40))
                           send_item(1'($urandom_range(1)), $urandom_range(3) != 0);
                    1: convert(SAMPLE_W'($urandom_range(1023)), 1'b1);
                    default: begin
                        // aim at the levels and the rails more often than at random values
                        case ($urandom_range(5))
                            0:       target = '0;
                            1:       target = '1;
                            2:       target = lvl1_q;
                            3:       target = lvl2_q + 1'b1;
                            4:       target = lvl3_q;
                            default: target = SAMPLE_W'($urandom_range(1023));
                        endcase
                        convert(target, 1'b0);
                    end
                endcase
            end
        end
    endtask

    // Longest serial clock phases, channel and mode at their top values: run through a
    // full low phase so the tick counter climbs to its top value before the clock rises.
    task automatic test_slow_clock;
        program_regs(10'd7, 10'd1, 10'd255, 10'd100, 10'd200, 10'd300);
        repeat (SLOW_TICKS) send_item(1'($urandom_range(1)), 1'b1);
    endtask

    // Hold the receiver off while ticks keep coming, so the block stalls its input.
    task automatic test_backpressure;
        program_regs(CFG_DATA_W'($urandom_range(7)), CFG_DATA_W'($urandom_range(1)), 10'd1,
                     10'd256, 10'd512, 10'd768);
        hold_left = 300;
        repeat (3) convert(SAMPLE_W'($urandom_range(1023)), 1'b0);
    endtask

    initial begin
        aresetn       = 1'b0;
        cfg_we        = 1'b0;
        cfg_addr      = REG_CHANNEL;
        cfg_wdata     = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_idle_pct = 37;
        recv_idle_pct = 45;
        test_idle_outputs();
        test_full_scale();
        test_level_edges();
        test_run_release();
        test_unused_regs();
        test_random(37, 45, 90);
        test_random(45, 37, 90);
        test_random(0, 0, 90);
        test_slow_clock();
        test_backpressure();

        // drain, then keep watching for stray result items
        settle();
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (fail_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

    initial begin
        #(LIMIT_NS);
        $display("%0t: run limit reached", $time);
        $display("testbench failed");
        $finish;
    end

endmodule

/* files.f */
sv/sadc_pkg.sv
sv/spi_adc_sampler_bar_graph.sv
dv/testbench.sv
